FILE: rtl/btpl_pkg.sv
// Package: shared item types, walker states and default sizes for the trie lookup engine.
`default_nettype none
package btpl_pkg;

    localparam int NODES_DEFAULT     = 8192;
    localparam int PORT_BITS_DEFAULT = 16;
    localparam int ADDR_BITS_DEFAULT = 32;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int PORT_W = 16;
    localparam int WIDE_W = 32;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  prefix_len;
        logic [PORT_W-1:0] route_port;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [PORT_W-1:0] match_port;
        logic              status;
    } rsp_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  plen;
        logic [WIDE_W-1:0] port;
    } cmd_t;

    typedef enum logic [0:0] {
        WALK_IDLE,
        WALK_STEP
    } walk_state_t;

endpackage
`default_nettype wire

FILE: rtl/binary_trie_prefix_lookup.sv
// Top level: longest-prefix-match engine on a one-bit-per-level trie.
//
//  channel | signals                        | item
//  --------+--------------------------------+----------------------------------------
//  request | req_valid, req_stall, req_item | kind, address, prefix_len, route_port
//  result  | rsp_valid, rsp_stall, rsp_item | found, match_port, status
//
// A lookup walks the trie level by level until the last address bit or a missing
// child; an insert walks down to prefix_len, or ends with a full status when no node
// is free. Node words come from the registered read port of the node ram. The front
// register and queue sit ahead of the walker and accept items during a walk.
// Reset clears the root node and the allocation pointer in flip-flops; no clearing pass.
// A stalled result holds in the output register while the walker takes the next item.
`default_nettype none
module binary_trie_prefix_lookup #(
    parameter int NODES     = btpl_pkg::NODES_DEFAULT,
    parameter int PORT_BITS = btpl_pkg::PORT_BITS_DEFAULT,
    parameter int ADDR_BITS = btpl_pkg::ADDR_BITS_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire btpl_pkg::req_t  req_item,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output btpl_pkg::rsp_t       rsp_item
);

    logic           front_valid;
    logic           queue_full;
    btpl_pkg::cmd_t front_cmd;
    logic           head_valid;
    logic           head_stall;
    btpl_pkg::cmd_t head_cmd;

    btpl_front #(
        .ADDR_BITS (ADDR_BITS),
        .PORT_BITS (PORT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .cmd_valid (front_valid),
        .cmd_full  (queue_full),
        .cmd_item  (front_cmd)
    );

    btpl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .full       (queue_full),
        .push_item  (front_cmd),
        .head_valid (head_valid),
        .head_stall (head_stall),
        .head_item  (head_cmd)
    );

    btpl_walk #(
        .NODES     (NODES),
        .PORT_BITS (PORT_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd_stall (head_stall),
        .cmd_item  (head_cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule
`default_nettype wire

FILE: rtl/btpl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module btpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/btpl_front.sv
// Front stage: accept items, normalize address, prefix length and port into commands.
`default_nettype none
module btpl_front #(
    parameter int ADDR_BITS = btpl_pkg::ADDR_BITS_DEFAULT,
    parameter int PORT_BITS = btpl_pkg::PORT_BITS_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire btpl_pkg::req_t  req_item,
    output logic                 cmd_valid,
    input  wire logic            cmd_full,
    output btpl_pkg::cmd_t       cmd_item
);

    localparam logic [btpl_pkg::WIDE_W-1:0] PORT_MASK = 32'hFFFF_FFFF >> (32 - PORT_BITS);
    localparam logic [btpl_pkg::LEN_W-1:0]  MAX_LEN   = btpl_pkg::LEN_W'(ADDR_BITS);

    logic           front_valid_reg, front_valid_next;
    btpl_pkg::cmd_t front_cmd_reg, front_cmd_next;
    logic           accept, push;

    assign req_stall = front_valid_reg && cmd_full;
    assign accept    = req_valid && !req_stall;
    assign push      = front_valid_reg && !cmd_full;
    assign cmd_valid = front_valid_reg;
    assign cmd_item  = front_cmd_reg;

    always_comb
    begin
        front_cmd_next.kind = req_item.kind;
        front_cmd_next.addr = req_item.address << (32 - ADDR_BITS);
        front_cmd_next.plen = (req_item.prefix_len > MAX_LEN) ? MAX_LEN : req_item.prefix_len;
        front_cmd_next.port = btpl_pkg::WIDE_W'(req_item.route_port) & PORT_MASK;
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
        else
        begin
            front_valid_next = front_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_cmd_reg <= front_cmd_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/btpl_queue.sv
// Short command queue between the front stage and the trie walker.
`default_nettype none
module btpl_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 full,
    input  wire btpl_pkg::cmd_t  push_item,
    output logic                 head_valid,
    input  wire logic            head_stall,
    output btpl_pkg::cmd_t       head_item
);

    localparam int CNT_W = btpl_pkg::QPTR_W + 1;

    btpl_pkg::cmd_t                entry_reg [btpl_pkg::QDEPTH];
    logic [btpl_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [btpl_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          push, pop;

    assign full       = (count_reg == CNT_W'(btpl_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign push       = push_valid && !full;
    assign pop        = head_valid && !head_stall;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/btpl_walk.sv
// Back stage: walk the trie one level per cycle for lookups and inserts, hold the result.
`default_nettype none
module btpl_walk #(
    parameter int NODES     = btpl_pkg::NODES_DEFAULT,
    parameter int PORT_BITS = btpl_pkg::PORT_BITS_DEFAULT,
    parameter int ADDR_BITS = btpl_pkg::ADDR_BITS_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_stall,
    input  wire btpl_pkg::cmd_t  cmd_item,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output btpl_pkg::rsp_t       rsp_item
);

    localparam int IDX_W  = $clog2(NODES);
    localparam int NF_W   = IDX_W + 1;
    localparam int WORD_W = 2 * IDX_W + 1 + PORT_BITS;
    localparam logic [btpl_pkg::LEN_W-1:0] LAST_LEVEL = btpl_pkg::LEN_W'(ADDR_BITS);
    localparam logic [NF_W-1:0] NF_LIMIT = NF_W'(NODES);

    btpl_pkg::walk_state_t       state_reg, state_next;
    btpl_pkg::cmd_t              cmd_reg, cmd_next;
    logic [btpl_pkg::LEN_W-1:0]  level_reg, level_next;
    logic [btpl_pkg::ADDR_W-1:0] shift_reg, shift_next;
    logic [IDX_W-1:0]            cur_reg, cur_next;
    logic                        fresh_reg, fresh_next;
    logic                        found_reg, found_next;
    logic [PORT_BITS-1:0]        best_reg, best_next;
    logic [NF_W-1:0]             next_free_reg, next_free_next;
    logic [IDX_W-1:0]            root_left_reg, root_left_next;
    logic [IDX_W-1:0]            root_right_reg, root_right_next;
    logic                        root_route_reg, root_route_next;
    logic [PORT_BITS-1:0]        root_port_reg, root_port_next;
    logic                        out_valid_reg, out_valid_next;
    btpl_pkg::rsp_t              out_item_reg, out_item_next;

    logic                        ram_we, ram_re;
    logic [IDX_W-1:0]            ram_waddr, ram_raddr;
    logic [WORD_W-1:0]           ram_wdata, ram_rdata;

    logic [IDX_W-1:0]            cw_left, cw_right, child;
    logic                        cw_route;
    logic [PORT_BITS-1:0]        cw_port;
    logic [IDX_W-1:0]            wr_left, wr_right;
    logic                        wr_route;
    logic [PORT_BITS-1:0]        wr_port;
    logic                        node_write;
    logic                        dir, at_plen, at_last, child_none, store_full, can_out;
    logic                        hit;
    logic [PORT_BITS-1:0]        hit_port;
    logic [btpl_pkg::WIDE_W-1:0] hit_port_wide;
    logic                        finish;

    btpl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_stall = (state_reg != btpl_pkg::WALK_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_item_reg;
    assign can_out   = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        if (cur_reg == '0)
        begin
            cw_left  = root_left_reg;
            cw_right = root_right_reg;
            cw_route = root_route_reg;
            cw_port  = root_port_reg;
        end
        else if (fresh_reg)
        begin
            cw_left  = '0;
            cw_right = '0;
            cw_route = 1'b0;
            cw_port  = '0;
        end
        else
        begin
            cw_left  = ram_rdata[WORD_W-1 -: IDX_W];
            cw_right = ram_rdata[WORD_W-1-IDX_W -: IDX_W];
            cw_route = ram_rdata[PORT_BITS];
            cw_port  = ram_rdata[PORT_BITS-1:0];
        end
        dir           = shift_reg[btpl_pkg::ADDR_W-1];
        child         = dir ? cw_right : cw_left;
        child_none    = (child == '0);
        at_plen       = (level_reg == cmd_reg.plen);
        at_last       = (level_reg == LAST_LEVEL);
        store_full    = (next_free_reg == NF_LIMIT);
        hit           = found_reg || cw_route;
        hit_port      = cw_route ? cw_port : best_reg;
        hit_port_wide = btpl_pkg::WIDE_W'(hit_port);
    end

    always_comb
    begin
        finish = 1'b0;
        if (state_reg == btpl_pkg::WALK_STEP)
        begin
            if (cmd_reg.kind == btpl_pkg::KIND_INSERT)
            begin
                finish = at_plen || (child_none && store_full);
            end
            else
            begin
                finish = at_last || child_none;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            btpl_pkg::WALK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = btpl_pkg::WALK_STEP;
                end
            end
            btpl_pkg::WALK_STEP:
            begin
                if (finish && can_out)
                begin
                    state_next = btpl_pkg::WALK_IDLE;
                end
            end
            default:
            begin
                state_next = btpl_pkg::WALK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        level_next      = level_reg;
        shift_next      = shift_reg;
        cur_next        = cur_reg;
        fresh_next      = fresh_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        next_free_next  = next_free_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_item_next   = out_item_reg;
        ram_re          = 1'b0;
        ram_raddr       = child;
        node_write      = 1'b0;
        wr_left         = cw_left;
        wr_right        = cw_right;
        wr_route        = cw_route;
        wr_port         = cw_port;
        case (state_reg)
            btpl_pkg::WALK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd_item;
                    level_next = '0;
                    shift_next = cmd_item.addr;
                    cur_next   = '0;
                    fresh_next = 1'b0;
                    found_next = 1'b0;
                    best_next  = '0;
                end
            end
            btpl_pkg::WALK_STEP:
            begin
                if (cmd_reg.kind == btpl_pkg::KIND_INSERT)
                begin
                    if (at_plen)
                    begin
                        if (can_out)
                        begin
                            node_write     = 1'b1;
                            wr_route       = 1'b1;
                            wr_port        = cmd_reg.port[PORT_BITS-1:0];
                            out_valid_next = 1'b1;
                            out_item_next  = '{found: 1'b0, match_port: '0,
                                               status: btpl_pkg::STATUS_OK};
                        end
                    end
                    else if (!child_none)
                    begin
                        ram_re     = 1'b1;
                        cur_next   = child;
                        fresh_next = 1'b0;
                        level_next = level_reg + 1'b1;
                        shift_next = shift_reg << 1;
                    end
                    else if (store_full)
                    begin
                        if (can_out)
                        begin
                            node_write     = 1'b1;
                            out_valid_next = 1'b1;
                            out_item_next  = '{found: 1'b0, match_port: '0,
                                               status: btpl_pkg::STATUS_FULL};
                        end
                    end
                    else
                    begin
                        node_write = 1'b1;
                        if (dir)
                        begin
                            wr_right = next_free_reg[IDX_W-1:0];
                        end
                        else
                        begin
                            wr_left = next_free_reg[IDX_W-1:0];
                        end
                        cur_next       = next_free_reg[IDX_W-1:0];
                        fresh_next     = 1'b1;
                        next_free_next = next_free_reg + 1'b1;
                        level_next     = level_reg + 1'b1;
                        shift_next     = shift_reg << 1;
                    end
                end
                else
                begin
                    found_next = hit;
                    best_next  = hit_port;
                    if (at_last || child_none)
                    begin
                        if (can_out)
                        begin
                            out_valid_next = 1'b1;
                            out_item_next  = '{found: hit,
                                               match_port: hit ? hit_port_wide[btpl_pkg::PORT_W-1:0]
                                                               : '0,
                                               status: btpl_pkg::STATUS_OK};
                        end
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        cur_next   = child;
                        fresh_next = 1'b0;
                        level_next = level_reg + 1'b1;
                        shift_next = shift_reg << 1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        ram_we          = node_write && (cur_reg != '0);
        ram_waddr       = cur_reg;
        ram_wdata       = {wr_left, wr_right, wr_route, wr_port};
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        root_route_next = root_route_reg;
        root_port_next  = root_port_reg;
        if (node_write && (cur_reg == '0))
        begin
            root_left_next  = wr_left;
            root_right_next = wr_right;
            root_route_next = wr_route;
            root_port_next  = wr_port;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= btpl_pkg::WALK_IDLE;
            next_free_reg  <= NF_W'(1);
            root_left_reg  <= '0;
            root_right_reg <= '0;
            root_route_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cur_reg        <= '0;
            fresh_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_free_reg  <= next_free_next;
            root_left_reg  <= root_left_next;
            root_right_reg <= root_right_next;
            root_route_reg <= root_route_next;
            out_valid_reg  <= out_valid_next;
            cur_reg        <= cur_next;
            fresh_reg      <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        level_reg     <= level_next;
        shift_reg     <= shift_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        root_port_reg <= root_port_next;
        out_item_reg  <= out_item_next;
    end

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg <= NF_LIMIT) && (next_free_reg != '0))
        else $error("allocation pointer out of range");

    a_no_root_ram: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_waddr != '0))
        else $error("root node written to node ram");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("node ram read and written in one cycle");

    a_fresh_node: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg |-> (cur_reg != '0) && (cmd_reg.kind == btpl_pkg::KIND_INSERT))
        else $error("fresh node outside an insert");

    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != $past(next_free_reg)) |-> fresh_reg && (cur_reg == $past(next_free_reg[IDX_W-1:0])))
        else $error("allocation without moving to the new node");

endmodule
`default_nettype wire
